@@ src/pacf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacf_pkg: shared types and constants for the command framer
// Command descriptor passed from the front end to the byte sequencer.
// ----------------------------------------------------------------------------
package pacf_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WHDR  = 2'd1;
	localparam logic [1:0] KIND_WDATA = 2'd2;

	localparam logic [1:0] AREA_X   = 2'd0;
	localparam logic [1:0] AREA_Y   = 2'd1;
	localparam logic [1:0] AREA_D   = 2'd2;
	localparam logic [1:0] AREA_INV = 2'd3;

	localparam logic [7:0]  STX_BYTE    = 8'h02;
	localparam logic [7:0]  ETX_BYTE    = 8'h03;
	localparam logic [7:0]  CHR_ZERO    = 8'h30;
	localparam logic [7:0]  CHR_ONE     = 8'h31;
	localparam logic [15:0] OFFS_X      = 16'h0080;
	localparam logic [15:0] OFFS_Y      = 16'h00A0;
	localparam logic [15:0] OFFS_D      = 16'h1000;
	localparam logic [8:0]  ADDR_MAX    = 9'h0FF;
	localparam logic [7:0]  RECIP_TEN   = 8'd205; // 2^11 / 10, rounded up
	localparam int          QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_REJECT,
		OP_HEADER,
		OP_DATA
	} op_t;

	// Byte position within the frame; data and tail positions follow the header.
	typedef enum logic [3:0] {
		STEP_STX   = 4'd0,
		STEP_CMD   = 4'd1,
		STEP_ADDR3 = 4'd2,
		STEP_ADDR2 = 4'd3,
		STEP_ADDR1 = 4'd4,
		STEP_ADDR0 = 4'd5,
		STEP_TENS  = 4'd6,
		STEP_ONES  = 4'd7,
		STEP_D0    = 4'd8,
		STEP_D1    = 4'd9,
		STEP_D2    = 4'd10,
		STEP_D3    = 4'd11,
		STEP_ETX   = 4'd12,
		STEP_SUMH  = 4'd13,
		STEP_SUML  = 4'd14,
		STEP_REJ   = 4'd15
	} step_t;

	typedef struct packed {
		op_t         op;
		logic        is_write;
		logic        tail;     // frame closes with ETX and checksum
		logic [15:0] payload;  // element address or data word
		logic [3:0]  tens;
		logic [3:0]  ones;
	} desc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'h0, v};
		end else begin
			r = 8'h37 + {4'h0, v};
		end
		return r;
	endfunction

endpackage

@@ src/pacf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacf_front: request checker and classifier
// Validates items, tracks the open write and builds command descriptors.
// ----------------------------------------------------------------------------
module pacf_front import pacf_pkg::*; #(
	parameter int MAX_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [1:0]  area,
	input  logic [8:0]  address,
	input  logic [5:0]  word_count,
	input  logic [15:0] data_word,
	input  logic        q_full,
	output logic        q_push,
	output desc_t       q_desc
);

	localparam logic [5:0] MaxCnt = 6'(MAX_WORDS);

	logic        write_open_q;
	logic [5:0]  words_left_q;
	logic [5:0]  words_dec;
	logic        bad_req;
	logic [15:0] elem_addr;
	logic [6:0]  byte_cnt;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  ones_full;

	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;
	assign words_dec = words_left_q - 6'd1;
	assign bad_req   = write_open_q || (area == AREA_INV) || (address > ADDR_MAX)
		|| (word_count > MaxCnt);

	always_comb begin
		unique case (area)
			AREA_X:  elem_addr = {7'd0, address} + OFFS_X;
			AREA_Y:  elem_addr = {7'd0, address} + OFFS_Y;
			default: elem_addr = {6'd0, address, 1'b0} + OFFS_D;
		endcase
	end

	// byte count split into decimal digits by reciprocal multiply
	assign byte_cnt  = {word_count, 1'b0};
	assign tens_prod = 15'(byte_cnt) * 15'(RECIP_TEN);
	assign tens      = tens_prod[14:11];
	assign ones_full = byte_cnt - (7'(tens) * 7'd10);

	always_comb begin
		q_desc          = '0;
		q_desc.op       = OP_REJECT;
		q_desc.is_write = (kind == KIND_WHDR);
		priority if (kind == KIND_WDATA) begin
			if (write_open_q) begin
				q_desc.op      = OP_DATA;
				q_desc.payload = data_word;
				q_desc.tail    = (words_dec == 6'd0);
			end
		end else if (kind == KIND_READ || kind == KIND_WHDR) begin
			if (!bad_req) begin
				q_desc.op      = OP_HEADER;
				q_desc.payload = elem_addr;
				q_desc.tens    = tens;
				q_desc.ones    = ones_full[3:0];
				q_desc.tail    = (kind == KIND_READ) || (word_count == 6'd0);
			end
		end else begin
			q_desc.op = OP_REJECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_open_q <= 1'b0;
			words_left_q <= '0;
		end else if (q_push) begin
			if (q_desc.op == OP_DATA) begin
				words_left_q <= words_dec;
				write_open_q <= !q_desc.tail;
			end else if (q_desc.op == OP_HEADER && !q_desc.tail) begin
				words_left_q <= word_count;
				write_open_q <= 1'b1;
			end
		end
	end

endmodule

@@ src/pacf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacf_queue: descriptor queue
// Small register FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module pacf_queue import pacf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output desc_t head
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	desc_t            entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full  = (count_q == CntW'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/pacf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacf_back: byte sequencer
// Walks one descriptor a byte per cycle while the output accepts, keeps the checksum, drives output.
// ----------------------------------------------------------------------------
module pacf_back import pacf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  desc_t      q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_byte,
	output logic       error
);

	step_t      step_q;
	logic       started_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       error_q;

	step_t      cur_step;
	step_t      next_step;
	logic       emit;
	logic [7:0] byte_c;
	logic       last_c;
	logic       summed;

	assign emit      = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = emit && last_c;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;
	assign error     = error_q;

	always_comb begin
		if (started_q) begin
			cur_step = step_q;
		end else begin
			unique case (q_head.op)
				OP_HEADER: cur_step = STEP_STX;
				OP_DATA:   cur_step = STEP_D0;
				default:   cur_step = STEP_REJ;
			endcase
		end
	end

	always_comb begin
		byte_c    = 8'h00;
		last_c    = 1'b0;
		summed    = 1'b1;
		next_step = step_t'(cur_step + 4'd1);
		unique case (cur_step)
			STEP_STX:   begin byte_c = STX_BYTE; summed = 1'b0; end
			STEP_CMD:   byte_c = q_head.is_write ? CHR_ONE : CHR_ZERO;
			STEP_ADDR3: byte_c = hex_char(q_head.payload[15:12]);
			STEP_ADDR2: byte_c = hex_char(q_head.payload[11:8]);
			STEP_ADDR1: byte_c = hex_char(q_head.payload[7:4]);
			STEP_ADDR0: byte_c = hex_char(q_head.payload[3:0]);
			STEP_TENS:  byte_c = hex_char(q_head.tens);
			STEP_ONES: begin
				byte_c    = hex_char(q_head.ones);
				last_c    = !q_head.tail;
				next_step = STEP_ETX;
			end
			STEP_D0:    byte_c = hex_char(q_head.payload[7:4]);
			STEP_D1:    byte_c = hex_char(q_head.payload[3:0]);
			STEP_D2:    byte_c = hex_char(q_head.payload[15:12]);
			STEP_D3: begin
				byte_c    = hex_char(q_head.payload[11:8]);
				last_c    = !q_head.tail;
				next_step = STEP_ETX;
			end
			STEP_ETX:   byte_c = ETX_BYTE;
			STEP_SUMH:  begin byte_c = hex_char(sum_q[7:4]); summed = 1'b0; end
			STEP_SUML: begin
				byte_c = hex_char(sum_q[3:0]);
				summed = 1'b0;
				last_c = 1'b1;
			end
			default: begin
				byte_c = 8'h00;
				summed = 1'b0;
				last_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_STX;
			started_q   <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				started_q   <= !last_c;
				step_q      <= next_step;
				if (cur_step == STEP_STX) begin
					sum_q <= '0;
				end else if (summed) begin
					sum_q <= sum_q + byte_c;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_c;
			last_q     <= last_c;
			error_q    <= (cur_step == STEP_REJ);
		end
	end

endmodule

@@ src/plc_ascii_command_framer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ascii_command_framer_top: controller command frame builder
// ASCII hex frames (STX, command, address, count, data, ETX, sum checksum).
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// s_*      in   tuser = kind; tdata = area, address, word_count, data_word
// m_*      out  tdata = out_byte; tlast = last_byte; tuser = error
//
// One output byte per clock while m_tready accepts, a pace set by the output
// register; a read frame is 11 bytes, a write header 8 (11 for an empty
// write), a data word 4 (7 with the closing tail), a rejected beat 1.
// Input beats are taken whenever the two-entry descriptor queue has room,
// so intake runs ahead of the sequencer; either side may stall freely.
// Reset (arst_n low) empties the queue, closes any open write and clears
// the checksum; nothing needs clearing after release.
// ----------------------------------------------------------------------------
module plc_ascii_command_framer_top import pacf_pkg::*; #(
	parameter int MAX_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] area, [10:2] address, [16:11] word_count, [32:17] data_word, rest 0
	input  logic [39:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	// [0] error
	output logic        m_tuser
);

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	desc_t q_desc;
	desc_t q_head;

	// Front end: checks requests, tracks the open write, computes the
	// element address and the decimal byte count digits.
	pacf_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser),
		.area      (s_tdata[1:0]),
		.address   (s_tdata[10:2]),
		.word_count(s_tdata[16:11]),
		.data_word (s_tdata[32:17]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	// Descriptor queue decouples intake from byte output.
	pacf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_desc(q_desc),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	// Back end: emits the frame bytes and owns the running checksum.
	pacf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.last_byte(m_tlast),
		.error    (m_tuser)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("descriptor pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("descriptor popped from empty queue");

	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
		else $error("error beat must be a single zero byte");

	a_pop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (m_tvalid && m_tlast))
		else $error("descriptor retired without a last beat");
`endif

endmodule
